// ===== src/quoted_field_scanner_core_defines.svh =====
// ---------------------------------------------------------------------------
// Quoted field scanner assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef QUOTED_FIELD_SCANNER_CORE_DEFINES_SVH
`define QUOTED_FIELD_SCANNER_CORE_DEFINES_SVH

// same-cycle implication
`define QFS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QFS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qfs_pkg.sv =====
// ---------------------------------------------------------------------------
// Quoted field scanner package
// Widths, register indexes, status codes and shared record types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qfs_pkg;

    localparam longint unsigned MAX_LENGTH = 65535;
    localparam int POS_W       = $clog2(MAX_LENGTH + 1);
    localparam int FIELD_LEN_W = 16;
    localparam int CHAR_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LENGTH);

    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT    = 2'd3;

    typedef enum logic [1:0] {
        STATUS_DELIM   = 2'd0,
        STATUS_END     = 2'd1,
        STATUS_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic [CHAR_W-1:0] delimiter_char;
        logic [CHAR_W-1:0] quote_char;
        logic [CHAR_W-1:0] escape_char;
        logic              strict_mode;
    } t_cfg;

    typedef struct packed {
        logic [CHAR_W-1:0] text_byte;
        logic              last_byte;
        logic              empty_input;
    } t_item;

    typedef struct packed {
        logic [POS_W-1:0]  byte_position;
        logic              quote_open;
        logic              close_pending;
        logic [POS_W-1:0]  escape_position;
        logic              escaped_seen;
        logic              quoted_seen;
        logic [CHAR_W-1:0] previous_byte;
        logic              decided;
    } t_scan;

    typedef struct packed {
        logic [FIELD_LEN_W-1:0] field_length;
        logic                   was_escaped;
        logic                   was_quoted;
        t_status                status;
    } t_result;

    localparam t_scan SCAN_CLEAR = '{default: '0};

    localparam t_cfg CFG_RESET = '{
        delimiter_char: 8'd44,
        quote_char:     8'd34,
        escape_char:    8'd92,
        strict_mode:    1'b0
    };

    localparam t_result RESULT_INVALID = '{
        field_length: '0,
        was_escaped:  1'b0,
        was_quoted:   1'b0,
        status:       STATUS_INVALID
    };

endpackage

`default_nettype wire

// ===== src/qfs_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Quoted field scanner configuration registers
// Delimiter, quote, escape and strict-mode registers behind a write port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qfs_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [qfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [qfs_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output qfs_pkg::t_cfg                       o_cfg
);
    import qfs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DELIMITER: n_cfg.delimiter_char = i_cfg_data[CHAR_W-1:0];
                CFG_QUOTE:     n_cfg.quote_char     = i_cfg_data[CHAR_W-1:0];
                CFG_ESCAPE:    n_cfg.escape_char    = i_cfg_data[CHAR_W-1:0];
                CFG_STRICT:    n_cfg.strict_mode    = i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/qfs_step.sv =====
// ---------------------------------------------------------------------------
// Quoted field scanner step logic
// Next scan state and optional result for one registered text byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qfs_step (
    input  wire qfs_pkg::t_cfg  i_cfg,
    input  wire qfs_pkg::t_scan i_scan,
    input  wire qfs_pkg::t_item i_item,
    output qfs_pkg::t_scan      o_next_scan,
    output logic                o_emit,
    output qfs_pkg::t_result    o_result
);
    import qfs_pkg::*;

    logic [CHAR_W-1:0] b;
    logic [POS_W-1:0]  pos;
    logic [POS_W:0]    pos_inc;
    logic [POS_W:0]    esc_inc;
    logic              v_qo;
    logic              v_cp;
    logic [POS_W-1:0]  v_ep;
    logic              v_esc_seen;
    logic              v_quo_seen;
    logic              v_dec;

    assign b       = i_item.text_byte;
    assign pos     = i_scan.byte_position;
    assign pos_inc = {1'b0, pos} + (POS_W+1)'(1);

    always_comb begin
        o_next_scan = i_scan;
        o_emit      = 1'b0;
        o_result    = RESULT_INVALID;
        v_qo        = i_scan.quote_open;
        v_cp        = i_scan.close_pending;
        v_ep        = i_scan.escape_position;
        v_esc_seen  = i_scan.escaped_seen;
        v_quo_seen  = i_scan.quoted_seen;
        v_dec       = 1'b0;
        esc_inc     = {1'b0, i_scan.escape_position} + (POS_W+1)'(1);

        if (i_item.empty_input) begin
            o_next_scan         = SCAN_CLEAR;
            o_emit              = 1'b1;
            o_result.status     = STATUS_END;
        end else if (i_scan.decided) begin
            if (i_item.last_byte) begin
                o_next_scan = SCAN_CLEAR;
            end
        end else if (pos >= MAX_POS) begin
            o_emit              = 1'b1;
            o_next_scan.decided = 1'b1;
            if (i_item.last_byte) begin
                o_next_scan = SCAN_CLEAR;
            end
        end else begin
            // resolve the lookahead of a pending closing quote
            if (i_scan.close_pending) begin
                v_qo = (b != i_cfg.delimiter_char);
                v_cp = 1'b0;
            end
            if (b == i_cfg.delimiter_char && !v_qo) begin
                o_emit                = 1'b1;
                o_result.field_length = FIELD_LEN_W'(pos);
                o_result.was_escaped  = i_scan.escaped_seen;
                o_result.was_quoted   = i_scan.quoted_seen;
                o_result.status       = STATUS_DELIM;
                v_dec                 = 1'b1;
            end else begin
                if (v_qo && i_cfg.quote_char != i_cfg.escape_char
                        && b == i_cfg.escape_char) begin
                    v_ep = pos;
                end
                if (b == i_cfg.quote_char) begin
                    if (!v_qo) begin
                        v_qo = 1'b1;
                        if (i_cfg.strict_mode && pos > POS_W'(1)
                                && i_scan.previous_byte != i_cfg.delimiter_char) begin
                            o_emit = 1'b1;
                            v_dec  = 1'b1;
                        end else if (i_cfg.quote_char == i_cfg.escape_char) begin
                            v_ep = pos;
                        end
                    end else begin
                        if (esc_inc == {1'b0, pos} && pos > POS_W'(1)) begin
                            v_esc_seen = 1'b1;
                        end else begin
                            v_ep = pos;
                            v_cp = 1'b1;
                        end
                        v_quo_seen = 1'b1;
                    end
                end
            end

            if (v_dec) begin
                o_next_scan.decided = 1'b1;
                if (i_item.last_byte) begin
                    o_next_scan = SCAN_CLEAR;
                end
            end else if (i_item.last_byte) begin
                o_emit      = 1'b1;
                o_next_scan = SCAN_CLEAR;
                if (!(v_qo && !v_cp && b != i_cfg.quote_char)) begin
                    o_result.field_length = FIELD_LEN_W'(pos_inc);
                    o_result.was_escaped  = v_esc_seen;
                    o_result.was_quoted   = v_quo_seen;
                    o_result.status       = STATUS_END;
                end
            end else begin
                o_next_scan.byte_position   = pos_inc[POS_W-1:0];
                o_next_scan.quote_open      = v_qo;
                o_next_scan.close_pending   = v_cp;
                o_next_scan.escape_position = v_ep;
                o_next_scan.escaped_seen    = v_esc_seen;
                o_next_scan.quoted_seen     = v_quo_seen;
                o_next_scan.previous_byte   = b;
                o_next_scan.decided         = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/quoted_field_scanner_core.sv =====
// ---------------------------------------------------------------------------
// Quoted field scanner core
// Finds the end of the first field of a byte string, honoring quotes and
// escapes, and reports its length, flags and status.
//
// Input channel: one text byte per transaction (i_text_byte, i_last_byte,
// i_empty_input) on i_in_valid / o_in_ready. Output channel: at most one
// result per string (o_field_length, o_was_escaped, o_was_quoted, o_status)
// on o_out_valid / i_out_ready. Configuration: write i_cfg_data to register
// i_cfg_index while i_cfg_we is high; write only while the block is idle.
//
// A byte taken into the input register is scanned from there, and its result,
// if any, is written to the result register and offered from then on.
// Throughput: one byte per cycle unless the receiver stalls, set by the scan
// state update between the input register and the result register.
// A stalled receiver holds the result register; the input register then
// keeps its byte and o_in_ready drops once it is full.
// Reset: configuration returns to its defaults (comma, double quote,
// backslash, strict mode off), scan state clears, both stages empty.
// No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_field_scanner_core_defines.svh"

module quoted_field_scanner_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [qfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [qfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [qfs_pkg::CHAR_W-1:0]      i_text_byte,
    input  wire logic                            i_last_byte,
    input  wire logic                            i_empty_input,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [qfs_pkg::FIELD_LEN_W-1:0]      o_field_length,
    output logic                                 o_was_escaped,
    output logic                                 o_was_quoted,
    output logic [1:0]                           o_status
);
    import qfs_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    logic    n_in_valid;
    t_scan   r_scan;
    t_scan   n_scan;
    t_result step_result;
    logic    step_emit;
    t_result r_out;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    fire;
    logic    in_take;

    qfs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    qfs_step u_step (
        .i_cfg       (cfg),
        .i_scan      (r_scan),
        .i_item      (r_in),
        .o_next_scan (n_scan),
        .o_emit      (step_emit),
        .o_result    (step_result)
    );

    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;
    assign in_take    = i_in_valid && o_in_ready;
    assign n_in_valid = in_take || (r_in_valid && !fire);
    assign n_out_valid = fire ? step_emit : (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_scan      <= SCAN_CLEAR;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (fire) begin
                r_scan <= n_scan;
            end
        end
    end

    // payload: load on transaction, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= '{text_byte: i_text_byte, last_byte: i_last_byte,
                      empty_input: i_empty_input};
        end
        if (fire && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_field_length = r_out.field_length;
    assign o_was_escaped  = r_out.was_escaped;
    assign o_was_quoted   = r_out.was_quoted;
    assign o_status       = r_out.status;

    `QFS_ASSERT_SAME(a_invalid_zero, r_out_valid && r_out.status == STATUS_INVALID, r_out.field_length == '0 && !r_out.was_escaped && !r_out.was_quoted, "invalid result carries data")
    `QFS_ASSERT_NEXT(a_last_clears, fire && r_in.last_byte, r_scan == SCAN_CLEAR, "scan state not cleared after last byte")
    `QFS_ASSERT_SAME(a_decided_quiet, fire && r_scan.decided && !r_in.empty_input, !step_emit, "result after decision")
    `QFS_ASSERT_NEXT(a_stall_holds, r_in_valid && r_out_valid && !i_out_ready, r_in_valid && $stable(r_in) && $stable(r_scan), "stalled stage changed")

endmodule

`default_nettype wire

// ===== bench/tb_quoted_field_scanner_core.sv =====
// ---------------------------------------------------------------------------
// Quoted field scanner core testbench
// Drives byte strings through the scanner under several delimiter, quote,
// escape and strict settings, with idle and stall patterns on both channels.
// A directed table covers the corner cases. Directed rows are checked against
// their own expected results, all others against a local scan predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quoted_field_scanner_core;
    import qfs_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_ITEMS   = 180;
    localparam int QUEUE_DEPTH   = 8;
    localparam int SETTLE_CYCLES = 4;

    localparam logic [CHAR_W-1:0] COMMA  = CFG_RESET.delimiter_char;
    localparam logic [CHAR_W-1:0] DQUOTE = CFG_RESET.quote_char;
    localparam logic [CHAR_W-1:0] BSLASH = CFG_RESET.escape_char;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle;

    typedef struct packed {
        t_item   item;
        logic    typed;
        t_result want;
    } t_stim;

    localparam t_result NO_RES = '0;

    localparam t_stim DIRECTED_ROWS [26] = '{
        '{'{8'hFF,   1'b0, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0, STATUS_END}},
        '{'{8'h61,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{COMMA,   1'b0, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0, STATUS_DELIM}},
        '{'{8'h78,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{COMMA,   1'b1, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0, STATUS_DELIM}},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h61,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b1, 1'b0}, 1'b1, '{16'd3, 1'b0, 1'b1, STATUS_END}},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h61,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{BSLASH,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{COMMA,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h7A,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h62,   1'b1, 1'b0}, 1'b1, RESULT_INVALID},
        '{'{8'h61,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h61,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{DQUOTE,  1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h62,   1'b1, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00,   1'b0, 1'b0}, 1'b0, NO_RES},
        '{'{8'h00,   1'b0, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0, STATUS_END}},
        '{'{8'hFF,   1'b1, 1'b0}, 1'b1, '{16'd1, 1'b0, 1'b0, STATUS_END}}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic [CHAR_W-1:0]      i_text_byte = '0;
    logic                   i_last_byte = 1'b0;
    logic                   i_empty_input = 1'b0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic [FIELD_LEN_W-1:0] o_field_length;
    logic                   o_was_escaped;
    logic                   o_was_quoted;
    logic [1:0]             o_status;

    t_cfg    scan_cfg = CFG_RESET;
    t_scan   scan_state = SCAN_CLEAR;
    t_stim   stim_q[$];
    t_result field_q[$];
    t_stim   cur_stim;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;
    int      accepted_count = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    quoted_field_scanner_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .i_empty_input  (i_empty_input),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_field_length (o_field_length),
        .o_was_escaped  (o_was_escaped),
        .o_was_quoted   (o_was_quoted),
        .o_status       (o_status)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // advance the scan state by one byte and return the field result, if any
    task automatic scan_byte(input t_item it, output logic produced, output t_result res);
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  next_pos;
        logic [CHAR_W-1:0] b;
        pos = scan_state.byte_position;
        next_pos = pos + 1'b1;
        b = it.text_byte;
        produced = 1'b0;
        res = NO_RES;
        if (it.empty_input) begin
            scan_state = SCAN_CLEAR;
            produced = 1'b1;
            res = '{16'd0, 1'b0, 1'b0, STATUS_END};
        end else if (scan_state.decided) begin
            if (it.last_byte) scan_state = SCAN_CLEAR;
        end else if (pos >= MAX_POS) begin
            produced = 1'b1;
            res = RESULT_INVALID;
            scan_state.decided = 1'b1;
            if (it.last_byte) scan_state = SCAN_CLEAR;
        end else begin
            if (scan_state.close_pending) begin
                scan_state.quote_open = (b != scan_cfg.delimiter_char);
                scan_state.close_pending = 1'b0;
            end
            if (b == scan_cfg.delimiter_char && !scan_state.quote_open) begin
                produced = 1'b1;
                res = '{pos[FIELD_LEN_W-1:0], scan_state.escaped_seen,
                        scan_state.quoted_seen, STATUS_DELIM};
                scan_state.decided = 1'b1;
            end else begin
                if (scan_state.quote_open && scan_cfg.quote_char != scan_cfg.escape_char
                        && b == scan_cfg.escape_char)
                    scan_state.escape_position = pos;
                if (b == scan_cfg.quote_char) begin
                    if (!scan_state.quote_open) begin
                        scan_state.quote_open = 1'b1;
                        if (scan_cfg.strict_mode && pos > 1
                                && scan_state.previous_byte != scan_cfg.delimiter_char) begin
                            produced = 1'b1;
                            res = RESULT_INVALID;
                            scan_state.decided = 1'b1;
                        end else if (scan_cfg.quote_char == scan_cfg.escape_char) begin
                            scan_state.escape_position = pos;
                        end
                    end else begin
                        if (scan_state.escape_position + 1'b1 == pos && pos > 1) begin
                            scan_state.escaped_seen = 1'b1;
                        end else begin
                            scan_state.escape_position = pos;
                            scan_state.close_pending = 1'b1;
                        end
                        scan_state.quoted_seen = 1'b1;
                    end
                end
            end
            if (!scan_state.decided) begin
                scan_state.previous_byte = b;
                scan_state.byte_position = next_pos;
                if (it.last_byte) begin
                    produced = 1'b1;
                    if (scan_state.quote_open && !scan_state.close_pending
                            && b != scan_cfg.quote_char)
                        res = RESULT_INVALID;
                    else
                        res = '{next_pos[FIELD_LEN_W-1:0], scan_state.escaped_seen,
                                scan_state.quoted_seen, STATUS_END};
                    scan_state = SCAN_CLEAR;
                end
            end else if (it.last_byte) begin
                scan_state = SCAN_CLEAR;
            end
        end
    endtask

    // input side: hold each transaction until taken, predict on acceptance
    always @(posedge i_clk) begin
        logic    produced;
        t_result predicted;
        logic    taken;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            taken = 1'b0;
            if (i_in_valid && o_in_ready) begin
                accepted_count++;
                scan_byte(cur_stim.item, produced, predicted);
                if (cur_stim.typed) field_q.push_back(cur_stim.want);
                else if (produced) field_q.push_back(predicted);
                taken = 1'b1;
            end
            if (!i_in_valid || taken) begin
                if (stim_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                    cur_stim = stim_q.pop_front();
                    i_in_valid    <= 1'b1;
                    i_text_byte   <= cur_stim.item.text_byte;
                    i_last_byte   <= cur_stim.item.last_byte;
                    i_empty_input <= cur_stim.item.empty_input;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // output side: random stall, check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (field_q.size() == 0) begin
                    $display("%0t: result expected none actual length %0d status %0d",
                             $time, o_field_length, o_status);
                    error_count++;
                end else begin
                    want = field_q.pop_front();
                    check_field("field_length", int'(want.field_length),
                                int'(o_field_length));
                    check_field("was_escaped", int'(want.was_escaped), int'(o_was_escaped));
                    check_field("was_quoted", int'(want.was_quoted), int'(o_was_quoted));
                    check_field("status", int'(want.status), int'(o_status));
                end
            end
            i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL quoted_field_scanner_core");
            $finish;
        end
    end

    task automatic set_idling(input t_idle mode);
        case (mode)
            IDLE_NONE: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
            IDLE_SENDER: begin
                sender_idle_pct = 86;
                receiver_stall_pct = 0;
            end
            IDLE_RECEIVER: begin
                sender_idle_pct = 0;
                receiver_stall_pct = 86;
            end
            default: begin
                sender_idle_pct = 28;
                receiver_stall_pct = 28;
            end
        endcase
    endtask

    task automatic apply_cfg(input t_cfg c);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DELIMITER;
        i_cfg_data  <= c.delimiter_char;
        @(posedge i_clk);
        i_cfg_index <= CFG_QUOTE;
        i_cfg_data  <= c.quote_char;
        @(posedge i_clk);
        i_cfg_index <= CFG_ESCAPE;
        i_cfg_data  <= c.escape_char;
        @(posedge i_clk);
        i_cfg_index <= CFG_STRICT;
        i_cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, c.strict_mode};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        scan_cfg = c;
    endtask

    task automatic send_item(input t_stim s);
        while (stim_q.size() >= QUEUE_DEPTH) @(posedge i_clk);
        stim_q.push_back(s);
    endtask

    task automatic send_byte(input logic [CHAR_W-1:0] b, input logic last, input logic empty);
        t_stim s;
        s.item  = '{b, last, empty};
        s.typed = 1'b0;
        s.want  = NO_RES;
        send_item(s);
    endtask

    // wait for all transactions and results, then let the pipeline settle
    task automatic drain();
        do begin
            while (stim_q.size() != 0 || i_in_valid || field_q.size() != 0)
                @(posedge i_clk);
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end while (stim_q.size() != 0 || i_in_valid || field_q.size() != 0);
    endtask

    function automatic logic [CHAR_W-1:0] plain_byte();
        logic [CHAR_W-1:0] b;
        do
            b = CHAR_W'($urandom_range(0, 255));
        while (b == scan_cfg.quote_char || b == scan_cfg.delimiter_char);
        return b;
    endfunction

    function automatic logic [CHAR_W-1:0] noisy_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return scan_cfg.delimiter_char;
        if (r < 22) return scan_cfg.quote_char;
        if (r < 30) return scan_cfg.escape_char;
        if (r < 35) return 8'h00;
        if (r < 40) return 8'hFF;
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // mostly well-formed quoted/plain fields, the rest empty inputs, noise and cut strings
    task automatic send_random_string();
        logic [CHAR_W-1:0] text[$];
        int   shape;
        int   nfields;
        int   len;
        logic cut;
        shape = $urandom_range(0, 99);
        cut = 1'b0;
        if (shape < 6) begin
            send_byte(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            if (shape < 76) begin
                nfields = $urandom_range(1, 3);
                for (int f = 0; f < nfields; f++) begin
                    if (f > 0) text.push_back(scan_cfg.delimiter_char);
                    if ($urandom_range(0, 1)) begin
                        text.push_back(scan_cfg.quote_char);
                        len = $urandom_range(0, 6);
                        repeat (len) begin
                            if ($urandom_range(0, 6) == 0) begin
                                text.push_back(scan_cfg.escape_char);
                                text.push_back(scan_cfg.quote_char);
                            end else begin
                                text.push_back(plain_byte());
                            end
                        end
                        text.push_back(scan_cfg.quote_char);
                    end else begin
                        repeat ($urandom_range(0, 6)) text.push_back(plain_byte());
                    end
                end
                if (text.size() == 0) text.push_back(plain_byte());
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                repeat (len) text.push_back(noisy_byte());
                cut = ($urandom_range(0, 9) == 0);
            end
            foreach (text[k]) send_byte(text[k], !cut && k == text.size() - 1, 1'b0);
            if (cut) send_byte(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
        end
    endtask

    function automatic t_cfg phase_cfg(input int phase);
        case (phase)
            0: return '{COMMA, DQUOTE, BSLASH, 1'b1};
            1: return '{8'h00, 8'hFF, 8'hFF, 1'b0};
            2: return '{8'hFF, 8'h00, 8'h00, 1'b1};
            4: return '{COMMA, DQUOTE, DQUOTE, 1'b0};
            5: return '{8'h7C, 8'h27, BSLASH, 1'b1};
            6: return '{DQUOTE, DQUOTE, BSLASH, 1'b0};
            default: return '{CHAR_W'($urandom_range(0, 255)),
                              CHAR_W'($urandom_range(0, 255)),
                              CHAR_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1))};
        endcase
    endfunction

    initial begin
        int start_count;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_idling(IDLE_NONE);
        foreach (DIRECTED_ROWS[r]) send_item(DIRECTED_ROWS[r]);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            apply_cfg(phase_cfg(phase));
            set_idling(t_idle'(phase % 4));
            start_count = accepted_count;
            while (accepted_count - start_count < PHASE_ITEMS) send_random_string();
            drain();
        end

        if (error_count == 0)
            $display("PASS quoted_field_scanner_core");
        else
            $display("FAIL quoted_field_scanner_core");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/qfs_pkg.sv
src/qfs_cfg_regs.sv
src/qfs_step.sv
src/quoted_field_scanner_core.sv
bench/tb_quoted_field_scanner_core.sv
